// ===== rtl/overlapping_framer_with_window_defines.svh =====
// ----------------------------------------------------------------------------
// Overlapping framer assertion macros
// Shared assertion forms for the checker of the overlapping framer.
// ----------------------------------------------------------------------------
`ifndef OVERLAPPING_FRAMER_WITH_WINDOW_DEFINES_SVH
`define OVERLAPPING_FRAMER_WITH_WINDOW_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define OFW_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define OFW_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Same-cycle implication that is also checked around reset.
`define OFW_ASSERT_RAW(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ===== rtl/ofw_pkg.sv =====
// ----------------------------------------------------------------------------
// Overlapping framer package
// Widths, register indexes, window codes, coefficient tables and the
// command and status types shared by the framer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ofw_pkg;

   localparam int FRAME_LEN  = 64;
   localparam int HIST_DEPTH = 64;
   localparam int HIST_AW    = $clog2(HIST_DEPTH);
   localparam int SAMPLE_W   = 16;
   localparam int POS_W      = 6;
   localparam int FNUM_W     = 16;
   localparam int SHIFT_W    = 8;
   localparam int WTYPE_W    = 2;
   localparam int CNT_W      = 8;
   localparam int COEF_W     = 16;
   localparam int PROD_W     = SAMPLE_W + COEF_W + 1;
   localparam int PROD_FRAC  = 15;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;
   localparam int SAMPLE_MAX = 2 ** (SAMPLE_W - 1) - 1;
   localparam int SAMPLE_MIN = -(2 ** (SAMPLE_W - 1));

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_SHIFT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_TYPE = 2'd1;

   localparam logic [WTYPE_W-1:0] WIN_RECT    = 2'd0;
   localparam logic [WTYPE_W-1:0] WIN_HAMMING = 2'd1;
   localparam logic [WTYPE_W-1:0] WIN_HANN    = 2'd2;

   localparam logic [SHIFT_W-1:0] SHIFT_RESET = 8'd32;
   localparam logic [COEF_W-1:0]  RECT_COEF   = 16'h8000;

   localparam int          WIN_DEN   = FRAME_LEN - 1;
   localparam logic [63:0] Q30_ONE   = 64'd1073741824;
   localparam logic [63:0] Q30_HALF  = 64'd536870912;
   localparam logic [63:0] PI_Q30    = 64'd3373259426;
   localparam logic [63:0] HAM_A_Q30 = 64'd578059647;
   localparam logic [63:0] HAM_B_Q30 = 64'd495682177;

   typedef logic [FRAME_LEN-1:0][COEF_W-1:0] coef_rom_type;

   typedef struct packed {
      logic accept;
      logic issue;
   } ofw_cmd_type;

   typedef struct packed {
      logic frame_hit;
      logic last_pos;
      logic advance;
   } ofw_status_type;

   // Window coefficient in Q15 for one frame position.
   function automatic logic [COEF_W-1:0] win_q15(input int unsigned idx, input logic is_hann);
      logic [63:0]        n;
      logic [63:0]        num;
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic [63:0]        mag;
      logic [63:0]        adj;
      logic [63:0]        ofs;
      logic signed [63:0] sum;
      logic signed [63:0] w;
      logic               neg;
      n = 64'(idx);
      if (2 * n > 64'(WIN_DEN)) begin
         n = 64'(WIN_DEN) - n;
      end
      num = 2 * n;
      neg = 1'b0;
      if (2 * num > 64'(WIN_DEN)) begin
         num = 64'(WIN_DEN) - num;
         neg = 1'b1;
      end
      x    = (PI_Q30 * num) / WIN_DEN;
      x2   = (x * x) >> 30;
      term = Q30_ONE;
      sum  = $signed(term);
      term = ((term * x2) >> 30) / 2;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 12;
      sum  = sum + $signed(term);
      term = ((term * x2) >> 30) / 30;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 56;
      sum  = sum + $signed(term);
      term = ((term * x2) >> 30) / 90;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 132;
      sum  = sum + $signed(term);
      term = ((term * x2) >> 30) / 182;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 240;
      sum  = sum + $signed(term);
      if (sum < 0) begin
         sum = 64'sd0;
      end
      if (sum > $signed(Q30_ONE)) begin
         sum = $signed(Q30_ONE);
      end
      mag = $unsigned(sum);
      if (is_hann) begin
         adj = (mag + 64'd1) >> 1;
         ofs = Q30_HALF;
      end else begin
         adj = (HAM_B_Q30 * mag + 64'd536870912) >> 30;
         ofs = HAM_A_Q30;
      end
      w = neg ? $signed(ofs) + $signed(adj) : $signed(ofs) - $signed(adj);
      if (w < 0) begin
         w = 64'sd0;
      end
      if (w > $signed(Q30_ONE)) begin
         w = $signed(Q30_ONE);
      end
      return COEF_W'(($unsigned(w) + 64'd16384) >> 15);
   endfunction

   function automatic coef_rom_type build_rom(input logic is_hann);
      coef_rom_type rom;
      for (int i = 0; i < FRAME_LEN; i++) begin
         rom[i] = win_q15(i, is_hann);
      end
      return rom;
   endfunction

   localparam coef_rom_type HAMM_ROM = build_rom(1'b0);
   localparam coef_rom_type HANN_ROM = build_rom(1'b1);

endpackage

`default_nettype wire

// ===== rtl/ofw_channels.sv =====
// ----------------------------------------------------------------------------
// Overlapping framer channels
// Valid/ready interfaces for the sample input, the result output and the
// register write port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ofw_req_if import ofw_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;
   logic                       start_of_signal;

   modport source (output valid, output sample, output start_of_signal, input ready);
   modport sink (input valid, input sample, input start_of_signal, output ready);
endinterface

interface ofw_rsp_if import ofw_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] windowed_sample;
   logic [POS_W-1:0]           position;
   logic [FNUM_W-1:0]          frame_index;
   logic                       last_in_frame;

   modport source (output valid, output windowed_sample, output position,
                   output frame_index, output last_in_frame, input ready);
   modport sink (input valid, input windowed_sample, input position,
                 input frame_index, input last_in_frame, output ready);
endinterface

interface ofw_csr_if import ofw_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/ofw_controller.sv =====
// ----------------------------------------------------------------------------
// Overlapping framer controller
// Accepts samples and, when a frame completes, sequences the reads of its
// samples into the datapath pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ofw_controller import ofw_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  ofw_status_type status,
   output ofw_cmd_type    cmd
);

   localparam int STATE_W = 1;
   localparam logic [STATE_W-1:0] ST_IDLE = 1'b0;
   localparam logic [STATE_W-1:0] ST_EMIT = 1'b1;

   logic [STATE_W-1:0] state_ff;
   logic [STATE_W-1:0] state_in;

   always_comb begin
      req_ready  = (state_ff == ST_IDLE);
      cmd.accept = req_valid && req_ready;
      cmd.issue  = (state_ff == ST_EMIT) && status.advance;
      state_in   = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.accept && status.frame_hit) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (cmd.issue && status.last_pos) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/ofw_datapath.sv =====
// ----------------------------------------------------------------------------
// Overlapping framer datapath
// Sample history memory, frame countdown, configuration registers and the
// read, multiply and round pipeline that produces windowed samples.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ofw_datapath import ofw_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  ofw_cmd_type                cmd,
   output ofw_status_type             status,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  logic                       req_start,
   ofw_rsp_if.source                  rsp_chan,
   ofw_csr_if.sink                    csr_chan
);

   logic signed [SAMPLE_W-1:0] hist_mem [HIST_DEPTH];

   logic [HIST_AW-1:0] wp_ff;
   logic [HIST_AW-1:0] wp_in;
   logic [HIST_AW-1:0] base_ff;
   logic [HIST_AW-1:0] base_in;
   logic [HIST_AW-1:0] rd_addr;
   logic [CNT_W-1:0]   cnt_ff;
   logic [CNT_W-1:0]   cnt_in;
   logic [CNT_W-1:0]   cnt_base;
   logic [CNT_W-1:0]   cnt_dec;
   logic [FNUM_W-1:0]  frames_ff;
   logic [FNUM_W-1:0]  frames_in;
   logic [FNUM_W-1:0]  frames_base;
   logic [FNUM_W-1:0]  fnum_ff;
   logic [FNUM_W-1:0]  fnum_in;
   logic [SHIFT_W-1:0] shift_ff;
   logic [SHIFT_W-1:0] shift_in;
   logic [WTYPE_W-1:0] wtype_ff;
   logic [WTYPE_W-1:0] wtype_in;
   logic [WTYPE_W-1:0] fwtype_ff;
   logic [WTYPE_W-1:0] fwtype_in;
   logic [POS_W-1:0]   idx_ff;
   logic [POS_W-1:0]   idx_in;
   logic               frame_hit;
   logic               adv;

   logic                       v1_ff;
   logic signed [SAMPLE_W-1:0] rd_ff;
   logic [COEF_W-1:0]          coef_ff;
   logic [COEF_W-1:0]          coef_in;
   logic [POS_W-1:0]           pos1_ff;
   logic [FNUM_W-1:0]          fnum1_ff;
   logic                       last1_ff;

   logic                     v2_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic [POS_W-1:0]         pos2_ff;
   logic [FNUM_W-1:0]        fnum2_ff;
   logic                     last2_ff;

   logic                       ov_ff;
   logic signed [SAMPLE_W-1:0] osamp_ff;
   logic signed [SAMPLE_W-1:0] osamp_in;
   logic signed [PROD_W-1:0]   rnd;
   logic [POS_W-1:0]           opos_ff;
   logic [FNUM_W-1:0]          ofnum_ff;
   logic                       olast_ff;

   assign adv            = !ov_ff || rsp_chan.ready;
   assign rd_addr        = base_ff + HIST_AW'(idx_ff);
   assign status.frame_hit = frame_hit;
   assign status.last_pos  = (idx_ff == POS_W'(FRAME_LEN - 1));
   assign status.advance   = adv;
   assign csr_chan.ready   = 1'b1;

   always_comb begin
      shift_in = shift_ff;
      wtype_in = wtype_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_FRAME_SHIFT: shift_in = csr_chan.data[SHIFT_W-1:0];
            CSR_WINDOW_TYPE: wtype_in = csr_chan.data[WTYPE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cnt_base    = req_start ? CNT_W'(FRAME_LEN) : cnt_ff;
      cnt_dec     = cnt_base - CNT_W'(1);
      frames_base = req_start ? '0 : frames_ff;
      frame_hit   = (cnt_dec == '0);
      wp_in       = wp_ff;
      cnt_in      = cnt_ff;
      frames_in   = frames_ff;
      base_in     = base_ff;
      fnum_in     = fnum_ff;
      fwtype_in   = fwtype_ff;
      idx_in      = idx_ff;
      if (cmd.accept) begin
         wp_in     = wp_ff + HIST_AW'(1);
         cnt_in    = cnt_dec;
         frames_in = frames_base;
         if (frame_hit) begin
            cnt_in    = (shift_ff == '0) ? CNT_W'(1) : CNT_W'(shift_ff);
            frames_in = frames_base + FNUM_W'(1);
            fnum_in   = frames_base;
            base_in   = wp_ff + HIST_AW'(1) - HIST_AW'(FRAME_LEN);
            fwtype_in = wtype_ff;
            idx_in    = '0;
         end
      end else if (cmd.issue) begin
         idx_in = idx_ff + POS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff     <= '0;
         cnt_ff    <= CNT_W'(FRAME_LEN);
         frames_ff <= '0;
         base_ff   <= '0;
         fnum_ff   <= '0;
         fwtype_ff <= WIN_RECT;
         idx_ff    <= '0;
         shift_ff  <= SHIFT_RESET;
         wtype_ff  <= WIN_RECT;
      end else begin
         wp_ff     <= wp_in;
         cnt_ff    <= cnt_in;
         frames_ff <= frames_in;
         base_ff   <= base_in;
         fnum_ff   <= fnum_in;
         fwtype_ff <= fwtype_in;
         idx_ff    <= idx_in;
         shift_ff  <= shift_in;
         wtype_ff  <= wtype_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         hist_mem[wp_ff] <= req_sample;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rd_ff <= hist_mem[rd_addr];
      end
   end

   always_comb begin
      unique case (fwtype_ff)
         WIN_HAMMING: coef_in = HAMM_ROM[idx_ff];
         WIN_HANN:    coef_in = HANN_ROM[idx_ff];
         default:     coef_in = RECT_COEF;
      endcase
   end

   assign prod_in = rd_ff * $signed({1'b0, coef_ff});

   always_comb begin
      rnd = (prod_ff + PROD_W'(2 ** (PROD_FRAC - 1))) >>> PROD_FRAC;
      if (rnd > PROD_W'(SAMPLE_MAX)) begin
         osamp_in = SAMPLE_W'(SAMPLE_MAX);
      end else if (rnd < PROD_W'(SAMPLE_MIN)) begin
         osamp_in = SAMPLE_W'(SAMPLE_MIN);
      end else begin
         osamp_in = SAMPLE_W'(rnd);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         ov_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= cmd.issue;
         v2_ff <= v1_ff;
         ov_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         coef_ff  <= coef_in;
         pos1_ff  <= idx_ff;
         fnum1_ff <= fnum_ff;
         last1_ff <= status.last_pos;
         prod_ff  <= prod_in;
         pos2_ff  <= pos1_ff;
         fnum2_ff <= fnum1_ff;
         last2_ff <= last1_ff;
         osamp_ff <= osamp_in;
         opos_ff  <= pos2_ff;
         ofnum_ff <= fnum2_ff;
         olast_ff <= last2_ff;
      end
   end

   assign rsp_chan.valid           = ov_ff;
   assign rsp_chan.windowed_sample = osamp_ff;
   assign rsp_chan.position        = opos_ff;
   assign rsp_chan.frame_index     = ofnum_ff;
   assign rsp_chan.last_in_frame   = olast_ff;

endmodule

`default_nettype wire

// ===== rtl/overlapping_framer_with_window.sv =====
// ----------------------------------------------------------------------------
// Overlapping framer with window
// A sample that completes no frame is written to the history memory; a sample
// that completes a frame starts one read of the history memory per result, and
// no new sample is accepted until the last position of that frame is issued.
// Results pass through registered read, multiply and round stages and follow
// one per cycle while the result channel is ready.
// Reset is synchronous: framing restarts and history contents are undefined.
`timescale 1ns / 1ps
`default_nettype none

module overlapping_framer_with_window import ofw_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   ofw_req_if.sink   req_chan,
   ofw_rsp_if.source rsp_chan,
   ofw_csr_if.sink   csr_chan
);

   ofw_cmd_type    cmd;
   ofw_status_type status;

   ofw_controller u_ofw_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   ofw_datapath u_ofw_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_sample (req_chan.sample),
      .req_start  (req_chan.start_of_signal),
      .rsp_chan   (rsp_chan),
      .csr_chan   (csr_chan)
   );

endmodule

`default_nettype wire

// ===== rtl/ofw_checker.sv =====
// ----------------------------------------------------------------------------
// Overlapping framer checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "overlapping_framer_with_window_defines.svh"

module ofw_checker import ofw_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [POS_W-1:0]  position,
   input logic [FNUM_W-1:0] frame_index,
   input logic              last_in_frame
);

   `OFW_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")
   `OFW_ASSERT_IMP(a_last_pos, clock, reset, rsp_valid, last_in_frame == (position == POS_W'(FRAME_LEN - 1)), "last flag does not match position")
   `OFW_ASSERT_IMP(a_frame_seq, clock, reset, rsp_valid && rsp_ready && !last_in_frame ##1 rsp_valid, (position == POS_W'($past(position) + POS_W'(1))) && (frame_index == $past(frame_index)), "frame sequence broken")
   `OFW_ASSERT_RAW(a_reset_idle, clock, $past(reset), !rsp_valid, "result valid right after reset")

endmodule

bind overlapping_framer_with_window ofw_checker u_ofw_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .position      (rsp_chan.position),
   .frame_index   (rsp_chan.frame_index),
   .last_in_frame (rsp_chan.last_in_frame)
);

`default_nettype wire
